FILE: rtl/core/matrix_column_product_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix column product unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX_COLUMN_PRODUCT_UNIT_MACROS_SVH
`define MATRIX_COLUMN_PRODUCT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define MCP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mcp check failed");
// Condition must never be true outside reset
`define MCP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mcp forbidden condition");
`else
`define MCP_ASSERT(lbl, clk, rst_n, prop)
`define MCP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: rtl/core/mcp_pkg.sv
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared codes, widths and types of the matrix column product unit.
// ----------------------------------------------------------------------------
package mcp_pkg;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_A_ROW_COUNT  = 1'b0;
    localparam logic CFG_INNER_LENGTH = 1'b1;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        OP_WR_A,
        OP_WR_B,
        OP_COMPUTE
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VAL_W-1:0]   value;
    } t_op;

endpackage

FILE: rtl/core/mcp_front.sv
// ----------------------------------------------------------------------------
// mcp_front
// Accepts input beats, drops unused command codes and commands with out-of-range indexes, and queues the rest.
// ----------------------------------------------------------------------------
module mcp_front import mcp_pkg::*; #(
    parameter int MAX_DIM = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [IDX_W-1:0]      i_row_index,
    input  logic [IDX_W-1:0]      i_col_index,
    input  logic [VAL_W-1:0]      i_element_value,
    output logic                  o_op_valid,
    output t_op                   o_op,
    input  logic                  i_op_pop
);

    localparam int               LIM   = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

    t_op                r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_count;

    logic               w_accept;
    logic               w_keep;
    logic               w_push;
    logic               w_row_ok;
    logic               w_col_ok;
    t_op                w_op;

    assign o_ready    = (r_count != QCNT_W'(QDEPTH));
    assign w_accept   = i_valid && o_ready;
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q[r_rp];

    assign w_row_ok = ({1'b0, i_row_index} < LIM_C);
    assign w_col_ok = ({1'b0, i_col_index} < LIM_C);

    // Classify the command; drop unused codes and out-of-range indexes
    always_comb begin
        w_op.row   = i_row_index;
        w_op.col   = i_col_index;
        w_op.value = i_element_value;
        w_op.kind  = OP_WR_A;
        w_keep     = 1'b0;
        unique case (i_command)
            CMD_WR_A: begin
                w_op.kind = OP_WR_A;
                w_keep    = w_row_ok && w_col_ok;
            end
            CMD_WR_B: begin
                w_op.kind = OP_WR_B;
                w_keep    = w_row_ok && w_col_ok;
            end
            CMD_COMPUTE: begin
                w_op.kind = OP_COMPUTE;
                w_keep    = w_col_ok;
            end
            default: begin
                w_keep    = 1'b0;
            end
        endcase
    end

    assign w_push = w_accept && w_keep;

    // Store the queued command
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_op_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({w_push, i_op_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/mcp_back.sv
// ----------------------------------------------------------------------------
// mcp_back
// Executes queued commands: element writes and pipelined column dot products.
// ----------------------------------------------------------------------------
`include "matrix_column_product_unit_macros.svh"

module mcp_back import mcp_pkg::*; #(
    parameter int MAX_DIM = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CNT_W-1:0]      i_rows,
    input  logic [CNT_W-1:0]      i_terms,
    input  logic                  i_op_valid,
    input  t_op                   i_op,
    output logic                  o_op_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [IDX_W-1:0]      o_result_row,
    output logic [VAL_W-1:0]      o_dot_sum,
    output logic                  o_last_row
);

    localparam int LIM   = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam int IW    = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 2 ** AW;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic             first;
        logic             last_term;
        logic             last_row;
        logic             zero;
    } t_tag;

    // Element stores
    logic [VAL_W-1:0]   a_mem [DEPTH];
    logic [VAL_W-1:0]   b_mem [DEPTH];

    // Issue control
    logic               r_busy;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_term;
    logic [IDX_W-1:0]   r_col;

    // Pipeline stages
    logic               r_s1_valid;
    t_tag               r_s1_tag;
    logic [VAL_W-1:0]   r_a_rd;
    logic [VAL_W-1:0]   r_b_rd;
    logic               r_s2_valid;
    t_tag               r_s2_tag;
    logic [VAL_W-1:0]   r_s2_prod;
    logic [VAL_W-1:0]   r_acc;

    // Output register
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_row;
    logic [VAL_W-1:0]   r_out_sum;
    logic               r_out_last;

    logic               w_advance;
    logic               w_a_we;
    logic               w_b_we;
    logic               w_start;
    logic               w_issue;
    logic               w_zero_terms;
    logic               w_last_term;
    logic               w_last_row;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_a_raddr;
    logic [AW-1:0]      w_b_raddr;
    logic [VAL_W-1:0]   w_prod;
    logic [VAL_W-1:0]   w_sum;
    t_tag               w_tag;

    // Pipeline moves whenever the output register is free or being drained
    assign w_advance = !r_out_valid || i_ready;

    // Take a command only between computes
    assign o_op_pop = i_op_valid && !r_busy;
    assign w_a_we   = o_op_pop && (i_op.kind == OP_WR_A);
    assign w_b_we   = o_op_pop && (i_op.kind == OP_WR_B);
    assign w_start  = o_op_pop && (i_op.kind == OP_COMPUTE) && (i_rows != '0);
    assign w_waddr  = {i_op.row[IW-1:0], i_op.col[IW-1:0]};

    // Term and row bookkeeping for the current issue slot
    assign w_issue      = r_busy && w_advance;
    assign w_zero_terms = (i_terms == '0);
    assign w_last_term  = w_zero_terms || ({1'b0, r_term} == i_terms - CNT_W'(1));
    assign w_last_row   = ({1'b0, r_row} == i_rows - CNT_W'(1));
    assign w_a_raddr    = {r_row[IW-1:0], r_term[IW-1:0]};
    assign w_b_raddr    = {r_term[IW-1:0], r_col[IW-1:0]};

    always_comb begin
        w_tag.row       = r_row;
        w_tag.first     = (r_term == '0);
        w_tag.last_term = w_last_term;
        w_tag.last_row  = w_last_row;
        w_tag.zero      = w_zero_terms;
    end

    // Walk rows and terms of the active compute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_term <= '0;
        end else if (w_start) begin
            r_busy <= 1'b1;
            r_row  <= '0;
            r_term <= '0;
        end else if (w_issue) begin
            if (w_last_term) begin
                r_term <= '0;
                if (w_last_row) begin
                    r_busy <= 1'b0;
                end else begin
                    r_row <= r_row + IDX_W'(1);
                end
            end else begin
                r_term <= r_term + IDX_W'(1);
            end
        end
    end

    // Latch the column of the compute
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_col <= i_op.col;
        end
    end

    // A store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            a_mem[w_waddr] <= i_op.value;
        end
        if (w_advance) begin
            r_a_rd <= a_mem[w_a_raddr];
        end
    end

    // B store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            b_mem[w_waddr] <= i_op.value;
        end
        if (w_advance) begin
            r_b_rd <= b_mem[w_b_raddr];
        end
    end

    assign w_prod = r_a_rd * r_b_rd;
    assign w_sum  = r_s2_tag.first ? r_s2_prod : r_acc + r_s2_prod;

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid  <= w_issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_tag.last_term;
        end
    end

    // Stage payload: tag, product, accumulate, result
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_tag  <= w_tag;
            r_s2_tag  <= r_s1_tag;
            r_s2_prod <= r_s1_tag.zero ? '0 : w_prod;
            if (r_s2_valid) begin
                r_acc <= w_sum;
                if (r_s2_tag.last_term) begin
                    r_out_row  <= r_s2_tag.row;
                    r_out_sum  <= w_sum;
                    r_out_last <= r_s2_tag.last_row;
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_result_row = r_out_row;
    assign o_dot_sum    = r_out_sum;
    assign o_last_row   = r_out_last;

    // A compute only runs with at least one row in use
    `MCP_ASSERT(busy_has_rows, i_clk, i_rst_n, r_busy |-> (i_rows != '0))
    // A finished row always lands in the output register
    `MCP_ASSERT(row_done_loads, i_clk, i_rst_n,
        (w_advance && r_s2_valid && r_s2_tag.last_term) |=> r_out_valid)
    // No element write while a compute is issuing reads
    `MCP_ASSERT_NEVER(write_during_compute, i_clk, i_rst_n, r_busy && (w_a_we || w_b_we))

endmodule

FILE: rtl/core/matrix_column_product_unit.sv
// ----------------------------------------------------------------------------
// matrix_column_product_unit
// Column-by-matrix product over stored integer matrices A and B.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel: write an element of A, write an
//   element of B, or compute one column of B against every row of A in use.
//   Writes take one beat and give no result. A compute gives one m_axis beat
//   per row of A in ascending order: tdata carries the row and its wrapped
//   32-bit dot product, tlast marks the final row of the column.
//   Row count and inner length are set through the i_cfg_* write port while
//   the unit is idle; both reset to 16.
//   Throughput: a four-entry command queue takes beats while the back end
//   works. A compute walks every row in use and max(inner_length, 1) terms
//   per row, one term per cycle while the pipeline is not stalled, limited
//   by the single read port of each element store. Each row's result is
//   registered after its last term passes the read and product registers.
//   Reset clears control state and the queue; the element stores are not
//   cleared, so every element must be written before it is used.
//   When m_axis_tready is low the result is held and the pipeline stalls;
//   the queue keeps accepting beats until it is full.
// ----------------------------------------------------------------------------
module matrix_column_product_unit import mcp_pkg::*; #(
    parameter int MAX_DIM = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write port
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    // Command stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [1:0] command, [5:2] row_index, [9:6] col_index, [41:10] element_value
    input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
    // Result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [3:0] result_row, [35:4] dot_sum
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                     m_axis_tlast
);

    localparam int               LIM   = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

    logic [CNT_W-1:0]  r_a_row_count;
    logic [CNT_W-1:0]  r_inner_length;
    logic [CNT_W-1:0]  w_rows;
    logic [CNT_W-1:0]  w_terms;

    logic              w_op_valid;
    t_op               w_op;
    logic              w_op_pop;
    logic [IDX_W-1:0]  w_result_row;
    logic [VAL_W-1:0]  w_dot_sum;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_row_count  <= CNT_W'(16);
            r_inner_length <= CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_A_ROW_COUNT:  r_a_row_count  <= i_cfg_wdata;
                CFG_INNER_LENGTH: r_inner_length <= i_cfg_wdata;
            endcase
        end
    end

    // Saturate counts to the stored matrix size
    assign w_rows  = (r_a_row_count  > LIM_C) ? LIM_C : r_a_row_count;
    assign w_terms = (r_inner_length > LIM_C) ? LIM_C : r_inner_length;

    mcp_front #(
        .MAX_DIM         (MAX_DIM)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_command       (s_axis_tdata[1:0]),
        .i_row_index     (s_axis_tdata[5:2]),
        .i_col_index     (s_axis_tdata[9:6]),
        .i_element_value (s_axis_tdata[41:10]),
        .o_op_valid      (w_op_valid),
        .o_op            (w_op),
        .i_op_pop        (w_op_pop)
    );

    mcp_back #(
        .MAX_DIM         (MAX_DIM)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rows          (w_rows),
        .i_terms         (w_terms),
        .i_op_valid      (w_op_valid),
        .i_op            (w_op),
        .o_op_pop        (w_op_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_result_row    (w_result_row),
        .o_dot_sum       (w_dot_sum),
        .o_last_row      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_dot_sum, w_result_row};

endmodule
